// ----- rtl/core/sgs_pkg.sv -----
// sgs_pkg: shared types and constants of the segmented Gaussian smoother.
// No dependencies; used by sgs_cell, the top level and the testbench.

package sgs_pkg;

   localparam int WIN_W       = 5;   // counts and window limits, enough for a radius of 16
   localparam int DIST_W      = WIN_W + 1;
   localparam int RADIUS_W    = 3;
   localparam int WEIGHT_W    = 16;
   localparam int NUM_WEIGHTS = 6;
   localparam int WIDX_W      = 3;
   localparam int TAP_W       = WEIGHT_W + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [TAP_W-1:0] UNITY_WEIGHT = 17'h10000;

   localparam logic [RADIUS_W-1:0] RADIUS_RESET = 3'd3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RADIUS   = 3'd0,
      CSR_WEIGHT_1 = 3'd1,
      CSR_WEIGHT_2 = 3'd2,
      CSR_WEIGHT_3 = 3'd3,
      CSR_WEIGHT_4 = 3'd4,
      CSR_WEIGHT_5 = 3'd5,
      CSR_WEIGHT_6 = 3'd6,
      CSR_UNUSED   = 3'd7
   } csr_index_type;

   typedef logic [NUM_WEIGHTS:1][WEIGHT_W-1:0] weight_array_type;

   typedef struct packed {
      logic [WIN_W-1:0] centre;
      logic [WIN_W-1:0] ahead_lim;
      logic [WIN_W-1:0] behind_lim;
   } window_type;

endpackage

// ----- rtl/core/sgs_cell.sv -----
// sgs_cell: one history slot of the smoother; holds a frame, weights it for
// the current window and adds it into the partial sums passed down the row.
// Depends on sgs_pkg.

module sgs_cell #(
   parameter int SAMPLE_BITS = 16,
   parameter int ACC_W       = 37,
   parameter int TOT_W       = 21,
   parameter int IDX         = 0
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                shift_en,
   input  logic [SAMPLE_BITS-1:0]              sample_in,
   output logic [SAMPLE_BITS-1:0]              sample_out,
   input  sgs_pkg::window_type                 window,
   input  sgs_pkg::weight_array_type           weights,
   input  logic signed [ACC_W-1:0]             acc_in,
   input  logic [TOT_W-1:0]                    tot_in,
   output logic signed [ACC_W-1:0]             acc_out,
   output logic [TOT_W-1:0]                    tot_out
);

   localparam logic [sgs_pkg::DIST_W-1:0] POS = sgs_pkg::DIST_W'(IDX);

   logic [SAMPLE_BITS-1:0]              sample_ff, sample_in_w;
   logic signed [SAMPLE_BITS+17:0]      product_ff, product_in;
   logic [sgs_pkg::TAP_W-1:0]           tap_ff, tap_in;
   logic signed [ACC_W-1:0]             acc_ff, acc_in_w;
   logic [TOT_W-1:0]                    tot_ff, tot_in_w;

   logic [sgs_pkg::DIST_W-1:0] centre;
   logic [sgs_pkg::DIST_W-1:0] offset;
   logic                       ahead_hit;
   logic                       behind_hit;

   always_comb begin
      centre     = {1'b0, window.centre};
      ahead_hit  = (POS <= centre) && ((centre - POS) <= {1'b0, window.ahead_lim});
      behind_hit = (POS > centre) && ((POS - centre) <= {1'b0, window.behind_lim});
      offset     = (POS <= centre) ? (centre - POS) : (POS - centre);

      tap_in = '0;
      if (ahead_hit || behind_hit) begin
         if (offset == '0) begin
            tap_in = sgs_pkg::UNITY_WEIGHT;
         end else if (offset <= sgs_pkg::DIST_W'(sgs_pkg::NUM_WEIGHTS)) begin
            tap_in = {1'b0, weights[offset[sgs_pkg::WIDX_W-1:0]]};
         end
      end

      sample_in_w = shift_en ? sample_in : sample_ff;
      product_in  = $signed(sample_ff) * $signed({1'b0, tap_ff});
      acc_in_w    = acc_in + ACC_W'(product_ff);
      tot_in_w    = tot_in + TOT_W'(tap_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sample_ff <= '0;
      end else begin
         sample_ff <= sample_in_w;
      end
      tap_ff     <= tap_in;
      product_ff <= product_in;
      acc_ff     <= acc_in_w;
      tot_ff     <= tot_in_w;
   end

   assign sample_out = sample_ff;
   assign acc_out    = acc_ff;
   assign tot_out    = tot_ff;

endmodule

// ----- rtl/core/sgs_divider.sv -----
// sgs_divider: serial restoring divider for round(acc / tot), one quotient bit
// per cycle, with rounding away from zero and saturation. Depends on no other file.

module sgs_divider #(
   parameter int SAMPLE_BITS = 16,
   parameter int ACC_W       = 37,
   parameter int TOT_W       = 21
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [ACC_W-1:0]     acc,
   input  logic [TOT_W-1:0]            tot,
   output logic                        done,
   output logic [SAMPLE_BITS-1:0]      result
);

   localparam int NUM_W = ACC_W + 1;
   localparam int REM_W = NUM_W - SAMPLE_BITS;
   localparam int CNT_W = $clog2(SAMPLE_BITS + 1);
   localparam logic [SAMPLE_BITS-1:0] POS_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};

   logic [REM_W-1:0]       rem_ff, rem_in;
   logic [SAMPLE_BITS-1:0] low_ff, low_in;
   logic [SAMPLE_BITS-1:0] quo_ff, quo_in;
   logic [REM_W-1:0]       den_ff, den_in;
   logic                   neg_ff, neg_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   busy_ff, busy_in;

   logic [ACC_W-1:0] mag;
   logic [NUM_W-1:0] num;
   logic [REM_W:0]   trial;
   logic             fits;

   always_comb begin
      mag   = acc[ACC_W-1] ? ACC_W'(-acc) : ACC_W'(acc);
      num   = {mag, 1'b0} + NUM_W'(tot);
      trial = {rem_ff, low_ff[SAMPLE_BITS-1]};
      fits  = trial >= {1'b0, den_ff};

      rem_in  = rem_ff;
      low_in  = low_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;

      if (start) begin
         rem_in  = num[NUM_W-1:SAMPLE_BITS];
         low_in  = num[SAMPLE_BITS-1:0];
         quo_in  = '0;
         den_in  = REM_W'({tot, 1'b0});
         neg_in  = acc[ACC_W-1];
         cnt_in  = CNT_W'(SAMPLE_BITS);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (cnt_ff != '0) begin
            rem_in = fits ? REM_W'(trial - {1'b0, den_ff}) : trial[REM_W-1:0];
            low_in = {low_ff[SAMPLE_BITS-2:0], 1'b0};
            quo_in = {quo_ff[SAMPLE_BITS-2:0], fits};
            cnt_in = cnt_ff - 1'b1;
         end else begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      low_ff <= low_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
      neg_ff <= neg_in;
   end

   // quotient never exceeds 2^(SAMPLE_BITS-1); only the positive side saturates
   always_comb begin
      if (neg_ff) begin
         result = ~quo_ff + 1'b1;
      end else if (quo_ff > POS_MAX) begin
         result = POS_MAX;
      end else begin
         result = quo_ff;
      end
   end

   assign done = busy_ff && (cnt_ff == '0);

endmodule

// ----- rtl/core/segmented_gaussian_smoother_unit.sv -----
// segmented_gaussian_smoother_unit: top level of the segmented Gaussian smoother.
// Depends on sgs_pkg, sgs_cell and sgs_divider.
//
//   channel  direction  contents
//   req_*    in         tdata: sample; tlast: segment_end
//   rsp_*    out        tdata: smoothed; tuser: frame_ends_segment; tlast: last_of_run
//   csr_*    in         write enable, register index, write data
//
// Each request is taken in, then handled as one pass per released frame and a
// closing scan. A pass is a scan step, a walk down the cell row (tap stage,
// product stage and one adder per cell), the serial divider and a hand-over of
// the result.
// A segment end releases up to MAX_RADIUS+1 frames from one request.
// Reset is synchronous; history and counts clear at once.
// A stalled result holds the next pass at its hand-over step only.

module segmented_gaussian_smoother_unit #(
   parameter int MAX_RADIUS  = 6,
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,

   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   input  logic [((SAMPLE_BITS+7)/8)*8-1:0]      req_tdata,   // [SAMPLE_BITS-1:0] sample
   input  logic                                  req_tlast,

   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   output logic [((SAMPLE_BITS+7)/8)*8-1:0]      rsp_tdata,   // [SAMPLE_BITS-1:0] smoothed
   output logic                                  rsp_tuser,   // [0] frame_ends_segment
   output logic                                  rsp_tlast,

   input  logic                                  csr_we,
   input  logic [sgs_pkg::CSR_INDEX_W-1:0]       csr_index,
   input  logic [sgs_pkg::CSR_DATA_W-1:0]        csr_wdata
);

   localparam int HIST    = 2 * MAX_RADIUS + 1;
   localparam int H_W     = $clog2(HIST);
   localparam int ACC_W   = SAMPLE_BITS + 17 + H_W;
   localparam int TOT_W   = 17 + H_W;
   localparam int CNT_W   = $clog2(MAX_RADIUS + 2);
   localparam int SUM_W   = $clog2(HIST + 3);
   localparam int TDATA_W = ((SAMPLE_BITS + 7) / 8) * 8;

   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SCAN = 5'b00010,
      ST_SUM  = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_OUT  = 5'b10000
   } state_type;

   state_type                   state_ff, state_in;
   logic [CNT_W-1:0]            ahead_ff, ahead_in;
   logic [CNT_W-1:0]            behind_ff, behind_in;
   logic                        seg_ff, seg_in;
   logic                        last_ff, last_in;
   logic                        ends_ff, ends_in;
   sgs_pkg::window_type         window_ff, window_in;
   logic [SUM_W-1:0]            sum_cnt_ff, sum_cnt_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_BITS-1:0]      rsp_data_ff, rsp_data_in;
   logic                        rsp_ends_ff, rsp_ends_in;
   logic                        rsp_last_ff, rsp_last_in;

   logic [sgs_pkg::RADIUS_W-1:0] radius_ff, radius_in;
   sgs_pkg::weight_array_type    weights_ff, weights_in;

   logic                        accept;
   logic                        div_start;
   logic                        div_done;
   logic [SAMPLE_BITS-1:0]      div_result;
   logic [CNT_W-1:0]            r_eff;
   logic [CNT_W-1:0]            centre;
   logic                        more;
   logic                        more_after;
   logic                        out_free;

   logic [SAMPLE_BITS-1:0]      chain_sample [HIST+1];
   logic signed [ACC_W-1:0]     chain_acc    [HIST+1];
   logic [TOT_W-1:0]            chain_tot    [HIST+1];

   // configuration registers
   always_comb begin
      radius_in  = radius_ff;
      weights_in = weights_ff;
      if (csr_we) begin
         unique case (sgs_pkg::csr_index_type'(csr_index))
            sgs_pkg::CSR_RADIUS:   radius_in     = csr_wdata[sgs_pkg::RADIUS_W-1:0];
            sgs_pkg::CSR_WEIGHT_1: weights_in[1] = csr_wdata;
            sgs_pkg::CSR_WEIGHT_2: weights_in[2] = csr_wdata;
            sgs_pkg::CSR_WEIGHT_3: weights_in[3] = csr_wdata;
            sgs_pkg::CSR_WEIGHT_4: weights_in[4] = csr_wdata;
            sgs_pkg::CSR_WEIGHT_5: weights_in[5] = csr_wdata;
            sgs_pkg::CSR_WEIGHT_6: weights_in[6] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff     <= sgs_pkg::RADIUS_RESET;
         weights_ff[1] <= 16'd39751;
         weights_ff[2] <= 16'd8869;
         weights_ff[3] <= 16'd728;
         weights_ff[4] <= 16'd22;
         weights_ff[5] <= 16'd0;
         weights_ff[6] <= 16'd0;
      end else begin
         radius_ff  <= radius_in;
         weights_ff <= weights_in;
      end
   end

   // cell row: history shifts on each request, sums run toward the last cell
   assign chain_sample[0] = req_tdata[SAMPLE_BITS-1:0];
   assign chain_acc[0]    = '0;
   assign chain_tot[0]    = '0;

   for (genvar i = 0; i < HIST; i++) begin : g_cell
      sgs_cell #(
         .SAMPLE_BITS (SAMPLE_BITS),
         .ACC_W       (ACC_W),
         .TOT_W       (TOT_W),
         .IDX         (i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .shift_en   (accept),
         .sample_in  (chain_sample[i]),
         .sample_out (chain_sample[i+1]),
         .window     (window_ff),
         .weights    (weights_ff),
         .acc_in     (chain_acc[i]),
         .tot_in     (chain_tot[i]),
         .acc_out    (chain_acc[i+1]),
         .tot_out    (chain_tot[i+1])
      );
   end

   sgs_divider #(
      .SAMPLE_BITS (SAMPLE_BITS),
      .ACC_W       (ACC_W),
      .TOT_W       (TOT_W)
   ) u_divider (
      .clock  (clock),
      .reset  (reset),
      .start  (div_start),
      .acc    (chain_acc[HIST]),
      .tot    (chain_tot[HIST]),
      .done   (div_done),
      .result (div_result)
   );

   // sequencer
   always_comb begin
      if (32'(radius_ff) > 32'(MAX_RADIUS)) begin
         r_eff = CNT_W'(MAX_RADIUS);
      end else begin
         r_eff = CNT_W'(radius_ff);
      end

      accept     = req_tvalid && req_tready;
      centre     = ahead_ff - 1'b1;
      more       = seg_ff ? (ahead_ff != '0) : (ahead_ff > r_eff);
      more_after = seg_ff ? (centre != '0) : (centre > r_eff);
      out_free   = !rsp_valid_ff || rsp_tready;
      div_start  = 1'b0;

      state_in     = state_ff;
      ahead_in     = ahead_ff;
      behind_in    = behind_ff;
      seg_in       = seg_ff;
      last_in      = last_ff;
      ends_in      = ends_ff;
      window_in    = window_ff;
      sum_cnt_in   = sum_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_ends_in  = rsp_ends_ff;
      rsp_last_in  = rsp_last_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (ahead_ff < CNT_W'(MAX_RADIUS + 1)) begin
                  ahead_in = ahead_ff + 1'b1;
               end
               seg_in   = req_tlast;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (more) begin
               window_in.centre     = sgs_pkg::WIN_W'(centre);
               window_in.ahead_lim  = sgs_pkg::WIN_W'((centre < r_eff) ? centre : r_eff);
               window_in.behind_lim = sgs_pkg::WIN_W'((behind_ff < r_eff) ? behind_ff : r_eff);
               last_in    = !more_after;
               ends_in    = seg_ff && (centre == '0);
               sum_cnt_in = '0;
               state_in   = ST_SUM;
            end else begin
               if (seg_ff) begin
                  ahead_in  = '0;
                  behind_in = '0;
               end
               state_in = ST_IDLE;
            end
         end
         ST_SUM: begin
            // tap stage, product stage and one adder per cell
            if (sum_cnt_ff == SUM_W'(HIST + 2)) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               sum_cnt_in = sum_cnt_ff + 1'b1;
            end
         end
         ST_DIV: begin
            if (div_done) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = div_result;
               rsp_ends_in  = ends_ff;
               rsp_last_in  = last_ff;
               ahead_in     = centre;
               if (behind_ff < CNT_W'(MAX_RADIUS)) begin
                  behind_in = behind_ff + 1'b1;
               end
               state_in = ST_SCAN;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         ahead_ff     <= '0;
         behind_ff    <= '0;
         seg_ff       <= 1'b0;
         sum_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         ahead_ff     <= ahead_in;
         behind_ff    <= behind_in;
         seg_ff       <= seg_in;
         sum_cnt_ff   <= sum_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      last_ff     <= last_in;
      ends_ff     <= ends_in;
      window_ff   <= window_in;
      rsp_data_ff <= rsp_data_in;
      rsp_ends_ff <= rsp_ends_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = TDATA_W'(rsp_data_ff);
   assign rsp_tuser  = rsp_ends_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- test/tb_segmented_gaussian_smoother_unit.sv -----
// Self-checking testbench for segmented_gaussian_smoother_unit: drives frames, predicts every
// smoothed result with its own window model, and checks results in order under random stalls.
// Depends on sgs_pkg and the smoother RTL.
`timescale 1ns / 100ps

module tb_segmented_gaussian_smoother_unit;

   localparam int MAX_RADIUS      = 6;
   localparam int SAMPLE_BITS     = 16;
   localparam int HIST_DEPTH      = 2 * MAX_RADIUS + 1;
   localparam int PASS_CYCLES     = 35;
   localparam int IDLE_CYCLES     = 2 * PASS_CYCLES;
   localparam int RANDOM_PHASES   = 7;
   localparam int ITEMS_PER_PHASE = 22;

   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = 16'sh7FFF;
   localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = 16'sh8000;

   localparam logic [sgs_pkg::WEIGHT_W-1:0] WEIGHT_RESET [1:sgs_pkg::NUM_WEIGHTS] =
      '{16'd39751, 16'd8869, 16'd728, 16'd22, 16'd0, 16'd0};

   typedef enum int unsigned {
      WEIGHTS_FULL,
      WEIGHTS_ZERO,
      WEIGHTS_RANDOM,
      WEIGHTS_DECAY
   } weight_profile_type;

   typedef struct {
      logic signed [SAMPLE_BITS-1:0] smoothed;
      logic                          ends;
      logic                          last;
   } frame_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [SAMPLE_BITS-1:0] req_tdata  = '0;   // [15:0] sample
   logic                   req_tlast  = 1'b0;

   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [SAMPLE_BITS-1:0] rsp_tdata;          // [15:0] smoothed
   logic                   rsp_tuser;          // [0] frame_ends_segment
   logic                   rsp_tlast;

   logic                            csr_we    = 1'b0;
   logic [sgs_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [sgs_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;

   // smoother model state and settings
   logic signed [SAMPLE_BITS-1:0]   history [0:HIST_DEPTH-1];
   int unsigned                     frames_behind;
   int unsigned                     frames_ahead;
   logic [sgs_pkg::RADIUS_W-1:0]    radius_reg;
   logic [sgs_pkg::WEIGHT_W-1:0]    weight_reg [1:sgs_pkg::NUM_WEIGHTS];

   frame_result_type                pending_smoothed [$];
   int unsigned                     mismatch_count = 0;
   logic                            steady = 1'b0;
   logic signed [SAMPLE_BITS-1:0]   last_sample = '0;

   segmented_gaussian_smoother_unit #(
      .MAX_RADIUS (MAX_RADIUS),
      .SAMPLE_BITS(SAMPLE_BITS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tlast (rsp_tlast),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // ---------------------------------------------------------------- model

   function automatic int unsigned active_radius();
      return (radius_reg > MAX_RADIUS) ? MAX_RADIUS : radius_reg;
   endfunction

   function automatic logic [sgs_pkg::TAP_W-1:0] tap_weight(int unsigned span);
      if (span == 0)
         return sgs_pkg::UNITY_WEIGHT;
      return {1'b0, weight_reg[span]};
   endfunction

   function automatic frame_result_type smooth_frame(int unsigned centre, logic ends);
      int unsigned        r, a, b;
      longint             acc, val;
      longint unsigned    total, mag, quot;
      frame_result_type   res;
      r = active_radius();
      a = (centre < r) ? centre : r;
      b = (frames_behind < r) ? frames_behind : r;
      acc = 0;
      total = 0;
      for (int unsigned k = 0; k <= a; k++) begin
         acc += longint'(history[centre - k]) * longint'(tap_weight(k));
         total += tap_weight(k);
      end
      for (int unsigned k = 1; k <= b; k++) begin
         if (centre + k < HIST_DEPTH) begin
            acc += longint'(history[centre + k]) * longint'(tap_weight(k));
            total += tap_weight(k);
         end
      end
      mag = (acc < 0) ? -acc : acc;
      quot = (2 * mag + total) / (2 * total);
      val = (acc < 0) ? -longint'(quot) : longint'(quot);
      if (val > longint'(SAMPLE_MAX))
         val = SAMPLE_MAX;
      if (val < longint'(SAMPLE_MIN))
         val = SAMPLE_MIN;
      res.smoothed = val[SAMPLE_BITS-1:0];
      res.ends = ends;
      res.last = 1'b0;
      if (frames_behind < MAX_RADIUS)
         frames_behind++;
      if (frames_ahead > 0)
         frames_ahead--;
      return res;
   endfunction

   function automatic void advance_smoother(logic signed [SAMPLE_BITS-1:0] value, logic seg_end);
      frame_result_type batch [$];
      int unsigned      c;
      for (int i = HIST_DEPTH - 1; i > 0; i--)
         history[i] = history[i - 1];
      history[0] = value;
      if (frames_ahead < MAX_RADIUS + 1)
         frames_ahead++;
      if (seg_end) begin
         while (frames_ahead > 0) begin
            c = frames_ahead - 1;
            batch.push_back(smooth_frame(c, c == 0));
         end
         frames_behind = 0;
         frames_ahead = 0;
      end else begin
         while (frames_ahead > active_radius()) begin
            c = frames_ahead - 1;
            batch.push_back(smooth_frame(c, 1'b0));
         end
      end
      if (batch.size() > 0)
         batch[batch.size() - 1].last = 1'b1;
      foreach (batch[i])
         pending_smoothed.push_back(batch[i]);
   endfunction

   // ---------------------------------------------------------------- drivers

   function automatic int unsigned pick_gap();
      int unsigned roll;
      if (steady)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 85)
         return $urandom_range(1, 3);
      if (roll < 97)
         return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic signed [SAMPLE_BITS-1:0] next_sample();
      case ($urandom_range(0, 5))
         0: last_sample = $urandom_range(0, 1) ? SAMPLE_MAX : SAMPLE_MIN;
         1, 2: last_sample = SAMPLE_BITS'($urandom);
         default: last_sample = last_sample + 16'($urandom_range(0, 511) - 256);
      endcase
      return last_sample;
   endfunction

   task automatic send_request(input logic signed [SAMPLE_BITS-1:0] value, input logic seg_end);
      int unsigned gap;
      gap = pick_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= seg_end;
      do @(posedge clock); while (!req_tready);
      advance_smoother(value, seg_end);
   endtask

   task automatic csr_write(input sgs_pkg::csr_index_type idx,
                            input logic [sgs_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      @(posedge clock);
      if (idx == sgs_pkg::CSR_RADIUS)
         radius_reg = value[sgs_pkg::RADIUS_W-1:0];
      else if (idx != sgs_pkg::CSR_UNUSED)
         weight_reg[idx] = value;
   endtask

   task automatic program_radius(input logic [sgs_pkg::RADIUS_W-1:0] r);
      logic [sgs_pkg::CSR_DATA_W-1:0] word;
      word = sgs_pkg::CSR_DATA_W'($urandom);
      word[sgs_pkg::RADIUS_W-1:0] = r;
      csr_write(sgs_pkg::CSR_RADIUS, word);
   endtask

   task automatic program_weights(input weight_profile_type profile);
      int unsigned w;
      w = $urandom_range(0, 65535);
      for (int i = 1; i <= sgs_pkg::NUM_WEIGHTS; i++) begin
         case (profile)
            WEIGHTS_FULL:   csr_write(sgs_pkg::csr_index_type'(i), 16'hFFFF);
            WEIGHTS_ZERO:   csr_write(sgs_pkg::csr_index_type'(i), 16'h0000);
            WEIGHTS_RANDOM: csr_write(sgs_pkg::csr_index_type'(i), 16'($urandom));
            default: begin
               csr_write(sgs_pkg::csr_index_type'(i), w[sgs_pkg::WEIGHT_W-1:0]);
               w = (w * $urandom_range(0, 65535)) >> 16;
            end
         endcase
      end
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_smoothed.size() != 0)
         @(posedge clock);
      repeat (IDLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_default_window();
      send_request(SAMPLE_MAX, 1'b0);
      send_request(SAMPLE_MIN, 1'b0);
      send_request(16'sh0000, 1'b0);
      send_request(-16'sd1, 1'b0);
      send_request(16'sd1, 1'b0);
      send_request(16'sh2AAA, 1'b1);
      send_request(16'shAAAA, 1'b1);   // one-frame segment
      wait_idle();
   endtask

   task automatic test_radius_zero();
      program_radius(3'd0);
      send_request(SAMPLE_MAX, 1'b0);
      send_request(SAMPLE_MIN, 1'b0);
      send_request(16'sh1234, 1'b1);
      wait_idle();
   endtask

   task automatic test_radius_over_max();
      program_radius(3'd7);
      program_weights(WEIGHTS_FULL);
      for (int i = 0; i < 8; i++)
         send_request(i[0] ? SAMPLE_MAX : SAMPLE_MIN, i == 7);
      wait_idle();
   endtask

   task automatic test_radius_change();
      program_radius(3'd4);
      program_weights(WEIGHTS_DECAY);
      for (int i = 0; i < 3; i++)
         send_request(next_sample(), 1'b0);
      wait_idle();
      program_radius(3'd1);            // releases the held backlog on the next request
      send_request(next_sample(), 1'b0);
      wait_idle();
      program_radius(3'd5);
      csr_write(sgs_pkg::CSR_UNUSED, 16'($urandom));
      send_request(next_sample(), 1'b0);
      send_request(next_sample(), 1'b1);
      wait_idle();
   endtask

   task automatic test_random_segments();
      int unsigned                  seg_left;
      logic [sgs_pkg::RADIUS_W-1:0] extreme_radius [4];
      extreme_radius = '{3'd0, 3'd7, 3'd6, 3'd1};
      seg_left = 0;
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_idle();
         steady = (phase % 3 == 2);
         program_radius((phase < 4) ? extreme_radius[phase] : 3'($urandom_range(0, 7)));
         program_weights(weight_profile_type'($urandom_range(0, 3)));
         csr_write(sgs_pkg::CSR_UNUSED, 16'($urandom));
         // segments run on across phases, so settings also change mid-segment
         repeat (ITEMS_PER_PHASE) begin
            if (seg_left == 0)
               seg_left = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(1, 16);
            seg_left--;
            send_request(next_sample(), seg_left == 0);
         end
      end
      steady = 1'b0;
      wait_idle();
   endtask

   // ---------------------------------------------------------------- checking

   always @(posedge clock) begin
      frame_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_smoothed.size() == 0) begin
            $display("%0t: unexpected request result, expected none, got %0d", $time,
                     $signed(rsp_tdata[SAMPLE_BITS-1:0]));
            mismatch_count++;
         end else begin
            want = pending_smoothed.pop_front();
            if (rsp_tdata[SAMPLE_BITS-1:0] !== want.smoothed) begin
               $display("%0t: smoothed expected %0d, actual %0d", $time, want.smoothed,
                        $signed(rsp_tdata[SAMPLE_BITS-1:0]));
               mismatch_count++;
            end
            if (rsp_tuser !== want.ends) begin
               $display("%0t: frame_ends_segment expected %0b, actual %0b", $time,
                        want.ends, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tlast !== want.last) begin
               $display("%0t: last_of_run expected %0b, actual %0b", $time,
                        want.last, rsp_tlast);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      int unsigned stall;
      @(posedge clock);
      forever begin
         rsp_tready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         stall = pick_gap();
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin
      for (int i = 0; i < HIST_DEPTH; i++)
         history[i] = '0;
      frames_behind = 0;
      frames_ahead = 0;
      radius_reg = sgs_pkg::RADIUS_RESET;
      for (int i = 1; i <= sgs_pkg::NUM_WEIGHTS; i++)
         weight_reg[i] = WEIGHT_RESET[i];
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_default_window();
      test_radius_zero();
      test_radius_over_max();
      test_radius_change();
      test_random_segments();

      wait_idle();
      if (mismatch_count == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

   initial begin
      #8_000_000;
      $display("FAILURE");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/sgs_pkg.sv
rtl/core/sgs_cell.sv
rtl/core/sgs_divider.sv
rtl/core/segmented_gaussian_smoother_unit.sv
test/tb_segmented_gaussian_smoother_unit.sv
